### rtl/brre_pkg.sv
// Shared types and constants for the bitmap row run encoder.
`default_nettype none

package brre_pkg;

   localparam int MAX_COLS  = 1024;
   localparam int MAX_ROWS  = 1024;
   localparam int COORD_W   = 10;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIM_W-1:0]   dim_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic {
      KIND_RUN     = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   // Everything one request produces: an optional run, then an optional summary.
   typedef struct packed {
      logic      has_run;
      logic      has_summary;
      coord_type run_row;
      coord_type run_first_col;
      coord_type run_last_col;
      coord_type box_top_row;
      coord_type box_bottom_row;
      coord_type box_left_col;
      coord_type box_right_col;
      logic      box_empty;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [Q_CNT_W-1:0] count;
   } q_status_type;

endpackage

`default_nettype wire

### rtl/brre_front.sv
// Front end: pixel accept, row/column counting, run detection and box tracking.
`default_nettype none

module brre_front
   import brre_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_pixel_set,
   output logic              req_stall,
   input  wire logic         csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   input  wire q_status_type q_status,
   output push_type          q_push
);

   // Clamp a dimension register to 1..top and return its last index.
   function automatic coord_type last_index(input dim_type v, input dim_type top);
      coord_type r;
      if (v == '0) begin
         r = '0;
      end else if (v > top) begin
         r = COORD_W'(top - 1'b1);
      end else begin
         r = COORD_W'(v - 1'b1);
      end
      return r;
   endfunction

   coord_type last_col_idx_ff, last_row_idx_ff;
   coord_type col_count_ff, col_count_in;
   coord_type row_count_ff, row_count_in;
   logic      in_run_ff, in_run_in;
   coord_type run_start_ff, run_start_in;
   coord_type min_row_ff, min_row_in;
   coord_type max_row_ff, max_row_in;
   coord_type min_col_ff, min_col_in;
   coord_type max_col_ff, max_col_in;
   logic      any_run_ff, any_run_in;

   logic      accept;
   logic      last_col, last_row;
   logic      emit_run, emit_sum;
   coord_type run_first, run_last;
   coord_type box_min_row, box_max_row, box_min_col, box_max_col;
   entry_type entry;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      last_col  = col_count_ff >= last_col_idx_ff;
      last_row  = row_count_ff >= last_row_idx_ff;
      emit_run  = req_pixel_set ? last_col : in_run_ff;
      emit_sum  = last_col && last_row;
      run_first = in_run_ff ? run_start_ff : col_count_ff;
      run_last  = req_pixel_set ? col_count_ff : col_count_ff - 1'b1;

      box_min_row = min_row_ff;
      box_max_row = max_row_ff;
      box_min_col = min_col_ff;
      box_max_col = max_col_ff;
      if (emit_run) begin
         if (!any_run_ff || row_count_ff < min_row_ff) box_min_row = row_count_ff;
         if (!any_run_ff || row_count_ff > max_row_ff) box_max_row = row_count_ff;
         if (!any_run_ff || run_first < min_col_ff)    box_min_col = run_first;
         if (!any_run_ff || run_last > max_col_ff)     box_max_col = run_last;
      end

      entry               = '0;
      entry.has_run       = emit_run;
      entry.has_summary   = emit_sum;
      if (emit_run) begin
         entry.run_row       = row_count_ff;
         entry.run_first_col = run_first;
         entry.run_last_col  = run_last;
      end
      if (any_run_ff || emit_run) begin
         entry.box_top_row    = box_min_row;
         entry.box_bottom_row = box_max_row;
         entry.box_left_col   = box_min_col;
         entry.box_right_col  = box_max_col;
      end else begin
         entry.box_empty = 1'b1;
      end

      q_push.push  = accept && (emit_run || emit_sum);
      q_push.entry = entry;

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      in_run_in    = in_run_ff;
      run_start_in = run_start_ff;
      min_row_in   = min_row_ff;
      max_row_in   = max_row_ff;
      min_col_in   = min_col_ff;
      max_col_in   = max_col_ff;
      any_run_in   = any_run_ff;

      if (accept) begin
         if (emit_run) begin
            min_row_in = box_min_row;
            max_row_in = box_max_row;
            min_col_in = box_min_col;
            max_col_in = box_max_col;
            any_run_in = 1'b1;
         end
         if (req_pixel_set && !last_col) begin
            in_run_in    = 1'b1;
            run_start_in = run_first;
         end else begin
            in_run_in = 1'b0;
         end
         if (last_col) begin
            col_count_in = '0;
            if (last_row) begin
               row_count_in = '0;
               min_row_in   = '1;
               max_row_in   = '0;
               min_col_in   = '1;
               max_col_in   = '0;
               any_run_in   = 1'b0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
            end
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_idx_ff <= COORD_W'(MAX_COLS - 1);
         last_row_idx_ff <= COORD_W'(MAX_ROWS - 1);
         col_count_ff    <= '0;
         row_count_ff    <= '0;
         in_run_ff       <= 1'b0;
         run_start_ff    <= '0;
         min_row_ff      <= '1;
         max_row_ff      <= '0;
         min_col_ff      <= '1;
         max_col_ff      <= '0;
         any_run_ff      <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == CSR_IMAGE_WIDTH) begin
            last_col_idx_ff <= last_index(csr_wdata, DIM_W'(MAX_COLS));
         end
         if (csr_write_en && csr_index == CSR_IMAGE_HEIGHT) begin
            last_row_idx_ff <= last_index(csr_wdata, DIM_W'(MAX_ROWS));
         end
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         min_row_ff   <= min_row_in;
         max_row_ff   <= max_row_in;
         min_col_ff   <= min_col_in;
         max_col_ff   <= max_col_in;
         any_run_ff   <= any_run_in;
      end
   end

endmodule

`default_nettype wire

### rtl/brre_queue.sv
// Short queue of per-request result entries between front and back end.
`default_nettype none

module brre_queue
   import brre_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire push_type     q_push,
   input  wire logic         q_pop,
   output entry_type         q_head,
   output q_status_type      q_status
);

   entry_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      q_status.full  = count_ff == Q_CNT_W'(Q_DEPTH);
      q_status.empty = count_ff == '0;
      q_status.count = count_ff;
      q_head         = entry_ff[rd_ptr_ff];
      do_push        = q_push.push && !q_status.full;
      do_pop         = q_pop && !q_status.empty;
      count_in       = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

`default_nettype wire

### rtl/brre_back.sv
// Back end: splits queue entries into run and summary results, output register.
`default_nettype none

module brre_back
   import brre_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire entry_type    q_head,
   input  wire q_status_type q_status,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_result_kind,
   output coord_type         rsp_run_row,
   output coord_type         rsp_run_first_col,
   output coord_type         rsp_run_last_col,
   output coord_type         rsp_box_top_row,
   output coord_type         rsp_box_bottom_row,
   output coord_type         rsp_box_left_col,
   output coord_type         rsp_box_right_col,
   output logic              rsp_box_empty,
   output logic              rsp_last_of_item
);

   logic            rsp_valid_ff;
   logic            sum_phase_ff;   // run of the head entry already sent
   result_kind_type kind_ff;
   coord_type       run_row_ff, run_first_ff, run_last_ff;
   coord_type       top_ff, bottom_ff, left_ff, right_ff;
   logic            empty_ff, last_ff;
   logic            load, take_run;

   assign load     = (!rsp_valid_ff || !rsp_stall) && !q_status.empty;
   assign take_run = q_head.has_run && !sum_phase_ff;
   assign q_pop    = load && !(take_run && q_head.has_summary);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sum_phase_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            sum_phase_ff <= take_run && q_head.has_summary;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (take_run) begin
            kind_ff      <= KIND_RUN;
            run_row_ff   <= q_head.run_row;
            run_first_ff <= q_head.run_first_col;
            run_last_ff  <= q_head.run_last_col;
            top_ff       <= '0;
            bottom_ff    <= '0;
            left_ff      <= '0;
            right_ff     <= '0;
            empty_ff     <= 1'b0;
            last_ff      <= !q_head.has_summary;
         end else begin
            kind_ff      <= KIND_SUMMARY;
            run_row_ff   <= '0;
            run_first_ff <= '0;
            run_last_ff  <= '0;
            top_ff       <= q_head.box_top_row;
            bottom_ff    <= q_head.box_bottom_row;
            left_ff      <= q_head.box_left_col;
            right_ff     <= q_head.box_right_col;
            empty_ff     <= q_head.box_empty;
            last_ff      <= 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_run_row        = run_row_ff;
   assign rsp_run_first_col  = run_first_ff;
   assign rsp_run_last_col   = run_last_ff;
   assign rsp_box_top_row    = top_ff;
   assign rsp_box_bottom_row = bottom_ff;
   assign rsp_box_left_col   = left_ff;
   assign rsp_box_right_col  = right_ff;
   assign rsp_box_empty      = empty_ff;
   assign rsp_last_of_item   = last_ff;

endmodule

`default_nettype wire

### rtl/bitmap_row_run_encoder.sv
// Top level of the bitmap row run encoder.
//
// Request channel: one binary pixel per request in raster order (req_valid,
// req_stall, req_pixel_set). Row and column are counted internally against
// image_width / image_height; the user must write these via csr_ while idle.
// Response channel: run records (row, first and last column, inclusive) as
// each run closes, and after the frame's last pixel a summary with the
// bounding box of all runs, or box_empty set when no pixel was set.
// rsp_last_of_item marks the final response caused by a pixel.
// Throughput: one pixel per clock while req_stall is low. A pixel that
// closes a run or ends the frame pushes an entry through the queue into the
// output register; a pixel doing both gives two responses, run then summary.
// The response port drains one response per clock from a 4-entry queue;
// when rsp_stall holds the queue fills and req_stall rises once it is full.
// Synchronous reset clears counters, run state and box tracking, empties the
// queue and sets both dimensions to 1024.
`default_nettype none

module bitmap_row_run_encoder
   import brre_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_pixel_set,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_result_kind,
   output logic [COORD_W-1:0]        rsp_run_row,
   output logic [COORD_W-1:0]        rsp_run_first_col,
   output logic [COORD_W-1:0]        rsp_run_last_col,
   output logic [COORD_W-1:0]        rsp_box_top_row,
   output logic [COORD_W-1:0]        rsp_box_bottom_row,
   output logic [COORD_W-1:0]        rsp_box_left_col,
   output logic [COORD_W-1:0]        rsp_box_right_col,
   output logic                      rsp_box_empty,
   output logic                      rsp_last_of_item
);

   push_type     q_push;
   entry_type    q_head;
   q_status_type q_status;
   logic         q_pop;

   brre_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_pixel_set (req_pixel_set),
      .req_stall     (req_stall),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_status      (q_status),
      .q_push        (q_push)
   );

   brre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   brre_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (q_head),
      .q_status           (q_status),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_run_row        (rsp_run_row),
      .rsp_run_first_col  (rsp_run_first_col),
      .rsp_run_last_col   (rsp_run_last_col),
      .rsp_box_top_row    (rsp_box_top_row),
      .rsp_box_bottom_row (rsp_box_bottom_row),
      .rsp_box_left_col   (rsp_box_left_col),
      .rsp_box_right_col  (rsp_box_right_col),
      .rsp_box_empty      (rsp_box_empty),
      .rsp_last_of_item   (rsp_last_of_item)
   );

   a_sum_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SUMMARY |-> rsp_last_of_item)
      else $error("summary response not marked last");

   a_empty_box_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SUMMARY && rsp_box_empty |->
         rsp_box_top_row == '0 && rsp_box_bottom_row == '0 &&
         rsp_box_left_col == '0 && rsp_box_right_col == '0)
      else $error("empty frame summary carries a box");

   a_run_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_RUN |-> rsp_run_first_col <= rsp_run_last_col)
      else $error("run ends before it starts");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= Q_CNT_W'(Q_DEPTH) && !(q_status.full && q_push.push))
      else $error("queue overflow");

endmodule

`default_nettype wire
